// ===== rtl/core/xml_entity_unescape_macros.svh =====
// ----------------------------------------------------------------------------
// xml entity unescape assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_UNESCAPE_MACROS_SVH
`define XML_ENTITY_UNESCAPE_MACROS_SVH

// plain property check
`define XEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the same cycle
`define XEU_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/core/xeu_pkg.sv =====
// ----------------------------------------------------------------------------
// xeu_pkg
// types, character codes and reference tables of the entity decoder
// ----------------------------------------------------------------------------
package xeu_pkg;

  localparam int unsigned NumNames = 5;

  typedef enum logic [2:0] {
    PH_PLAIN    = 3'd0,
    PH_NAME     = 3'd1,
    PH_NUMSTART = 3'd2,
    PH_NUM      = 3'd3,
    PH_DROP     = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e                phase;
    logic [7:0]            accum;
    logic                  hex_mode;
    logic [2:0]            name_pos;
    logic [NumNames-1:0]   name_cands;
    logic                  error_seen;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_mark;
    logic       ref_error;
  } res_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [4:0] DIGIT_NONE = 5'd16;
  localparam logic [4:0] RADIX_DEC  = 5'd10;
  localparam logic [4:0] RADIX_HEX  = 5'd16;
  localparam logic [2:0] NAME_POS_MAX = 3'd7;
  localparam logic [NumNames-1:0] ALL_CANDS = '1;

  // names: amp, lt, gt, quot, apos
  localparam logic [7:0] ENT_TEXT [NumNames][4] = '{
    '{8'h61, 8'h6d, 8'h70, 8'h00},
    '{8'h6c, 8'h74, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h00, 8'h00},
    '{8'h71, 8'h75, 8'h6f, 8'h74},
    '{8'h61, 8'h70, 8'h6f, 8'h73}
  };
  localparam logic [2:0] ENT_LEN [NumNames] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4};
  localparam logic [7:0] ENT_CHAR [NumNames] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

  localparam dec_state_t STATE_RESET = '{
    phase:      PH_PLAIN,
    accum:      8'h00,
    hex_mode:   1'b0,
    name_pos:   3'd0,
    name_cands: ALL_CANDS,
    error_seen: 1'b0
  };

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] v;
    v = DIGIT_NONE;
    if (c inside {[CH_0:CH_9]}) begin
      v = 5'(c - CH_0);
    end else if (c inside {[CH_LA:CH_LF]}) begin
      v = 5'(c - CH_LA) + 5'd10;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      v = 5'(c - CH_UA) + 5'd10;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/xeu_decoder.sv =====
// ----------------------------------------------------------------------------
// xeu_decoder
// per-string reference state and the single-byte decode step
// ----------------------------------------------------------------------------
module xeu_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          res_valid_o,
  output xeu_pkg::res_t res_o
);
  import xeu_pkg::*;

  dec_state_t state_q, state_d;
  logic       has;
  logic       fail;
  logic [7:0] b;
  logic [4:0] dv;
  logic       dig_ok;
  logic [7:0] acc_next;
  logic [NumNames-1:0] cands;

  assign dv       = digit_value(byte_i);
  assign dig_ok   = state_q.hex_mode ? (dv < RADIX_HEX) : (dv < RADIX_DEC);
  assign acc_next = state_q.hex_mode
                    ? {state_q.accum[3:0], dv[3:0]}
                    : 8'({state_q.accum[4:0], 3'b000} + {state_q.accum[6:0], 1'b0}
                         + {4'b0000, dv[3:0]});

  // next state
  always_comb begin
    state_d = state_q;
    has     = 1'b0;
    fail    = 1'b0;
    b       = 8'h00;
    cands   = state_q.name_cands;
    case (state_q.phase)
      PH_PLAIN: begin
        if (byte_i == CH_AMP) begin
          state_d.phase      = PH_NAME;
          state_d.name_pos   = 3'd0;
          state_d.name_cands = ALL_CANDS;
          if (last_i) fail = 1'b1;
        end else begin
          b   = byte_i;
          has = 1'b1;
        end
      end
      PH_NAME: begin
        if (state_q.name_pos == 3'd0 && byte_i == CH_HASH) begin
          state_d.phase    = PH_NUMSTART;
          state_d.accum    = 8'h00;
          state_d.hex_mode = 1'b0;
          if (last_i) begin
            has           = 1'b1;
            state_d.phase = PH_PLAIN;
          end
        end else if (byte_i == CH_SEMI) begin
          for (int k = 0; k < NumNames; k++) begin
            if (state_q.name_cands[k] && ENT_LEN[k] == state_q.name_pos) begin
              b   = ENT_CHAR[k];
              has = 1'b1;
            end
          end
          if (has) state_d.phase = PH_PLAIN;
          else fail = 1'b1;
        end else begin
          for (int k = 0; k < NumNames; k++) begin
            if (state_q.name_pos >= ENT_LEN[k] ||
                ENT_TEXT[k][state_q.name_pos[1:0]] != byte_i) begin
              cands[k] = 1'b0;
            end
          end
          state_d.name_cands = cands;
          if (state_q.name_pos != NAME_POS_MAX) state_d.name_pos = state_q.name_pos + 3'd1;
          if (cands == '0 || last_i) fail = 1'b1;
        end
      end
      PH_NUMSTART, PH_NUM: begin
        if (state_q.phase == PH_NUMSTART && byte_i == CH_X) begin
          state_d.hex_mode = 1'b1;
          state_d.phase    = PH_NUM;
          if (last_i) begin
            b             = state_q.accum;
            has           = 1'b1;
            state_d.phase = PH_PLAIN;
          end
        end else if (byte_i == CH_SEMI) begin
          b             = state_q.accum;
          has           = 1'b1;
          state_d.phase = PH_PLAIN;
        end else if (!dig_ok) begin
          fail = 1'b1;
        end else begin
          state_d.accum = acc_next;
          state_d.phase = PH_NUM;
          if (last_i) begin
            b             = acc_next;
            has           = 1'b1;
            state_d.phase = PH_PLAIN;
          end
        end
      end
      default: begin
      end
    endcase
    if (fail) begin
      state_d.error_seen = 1'b1;
      state_d.phase      = PH_DROP;
      has                = 1'b0;
      b                  = 8'h00;
    end
    res_o.out_byte  = b;
    res_o.has_byte  = has;
    res_o.end_mark  = last_i;
    res_o.ref_error = state_d.error_seen;
    if (last_i) state_d = STATE_RESET;
  end

  // outputs
  always_comb begin
    res_valid_o = has || last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/xml_entity_unescape.sv =====
// ----------------------------------------------------------------------------
// xml_entity_unescape
// byte stream decoder for xml named and numeric character references
// ----------------------------------------------------------------------------
// usage
//   input channel: in_byte_i with is_last_i marking the final byte of a string
//   output channel: out_byte_o, has_byte_o, end_mark_o, ref_error_o
//   a request moves when valid is high and stall is low
//   plain bytes and completed references give one result each; bytes inside
//   a reference give none; the last byte of a string always gives one result
//   an input request passes the input register, then the decode step and the output register
//   throughput: one byte per cycle while the output is not stalled, set by the single
//   decode step between the input register and the result register
//   a stalled output holds its result; the input register then fills and
//   in_stall_o rises, so at most two bytes sit inside the block
//   reset empties both registers and returns the decoder to plain text
//   an error drops the rest of the string and shows on its last result
// ----------------------------------------------------------------------------
`include "xml_entity_unescape_macros.svh"

module xml_entity_unescape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       end_mark_o,
  output logic       ref_error_o
);
  import xeu_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  res_t       out_q;
  logic       advance;
  logic       in_accept;
  logic       res_valid;
  res_t       res;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  xeu_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
      in_last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_q.out_byte;
  assign has_byte_o  = out_q.has_byte;
  assign end_mark_o  = out_q.end_mark;
  assign ref_error_o = out_q.ref_error;

  // empty results close a string and carry a zero byte
  `XEU_ASSERT_IMP(a_empty_is_end, out_valid_o && !has_byte_o, end_mark_o && out_byte_o == 8'h00, "empty result without end mark")
  // errors only on the closing result
  `XEU_ASSERT_IMP(a_err_at_end, out_valid_o && ref_error_o, end_mark_o && !has_byte_o, "error result carries a byte")
  // a held input byte survives an output stall
  `XEU_ASSERT(a_in_hold, (in_valid_q && out_valid_q && out_stall_i) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_last_q)), "input register lost under stall")
  // the input register never drains while the output is blocked
  `XEU_ASSERT_IMP(a_no_step_blocked, advance, !(out_valid_q && out_stall_i), "decode step while output blocked")

endmodule
